>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> src/ltoe_pkg.sv
// ----------------------------------------------------------------------------
// Line-table opcode encoder package
// Word types, standard opcodes and register indexes.
// ----------------------------------------------------------------------------
package ltoe_pkg;

  typedef struct packed {
    logic signed [31:0] line_delta;
    logic signed [31:0] addr_delta;
  } ltoe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } ltoe_out_t;

  localparam logic [7:0] OP_COPY         = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC   = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE = 8'd3;
  localparam logic [7:0] OP_CONST_ADD_PC = 8'd8;
  localparam logic [7:0] TOP_OPCODE      = 8'd255;

  localparam logic [1:0] REG_LINE_BASE   = 2'd0;
  localparam logic [1:0] REG_LINE_RANGE  = 2'd1;
  localparam logic [1:0] REG_OPCODE_BASE = 2'd2;
  localparam logic [1:0] REG_MIN_INSTR   = 2'd3;

endpackage

>>> src/line_table_opcode_encoder.sv
// ----------------------------------------------------------------------------
// Line-table opcode encoder
// Turns one line delta and one address delta into line-program bytes.
// ----------------------------------------------------------------------------
// The block takes one word at a time: busy stays high while a word is encoded,
// and a new word is taken only in idle. The shared radix-2 divider and the
// byte-serial LEB128 emitter set how long a word takes.
// Bytes leave one per strobe cycle and the receiver cannot stall.
// Synchronous reset returns the sequencer to idle and the configuration registers to reset.
`include "assert_macros.svh"

module line_table_opcode_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ltoe_pkg::ltoe_in_t   operands,
  output logic                 result_strobe,
  output ltoe_pkg::ltoe_out_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ltoe_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LCHK   = 13'b0000000000010,
    S_ACHK   = 13'b0000000000100,
    S_ADIV   = 13'b0000000001000,
    S_ZCHK   = 13'b0000000010000,
    S_SDIV   = 13'b0000000100000,
    S_SMUL   = 13'b0000001000000,
    S_DECIDE = 13'b0000010000000,
    S_CAP    = 13'b0000100000000,
    S_RDIV   = 13'b0001000000000,
    S_RMUL   = 13'b0010000000000,
    S_SLEB   = 13'b0100000000000,
    S_FINAL  = 13'b1000000000000
  } state_t;

  // Configuration registers
  logic [4:0] line_base;
  logic [6:0] line_range;
  logic [7:0] opcode_base;
  logic [4:0] min_instr_length;

  // Sequencer and datapath registers
  state_t             state;
  state_t             sleb_ret;
  logic signed [31:0] line_q;
  logic [31:0]        addr_q;
  logic               line_zero;
  logic [7:0]         adj;
  logic signed [31:0] sleb_val;
  logic [31:0]        div_quo;
  logic [7:0]         div_rem;
  logic [7:0]         div_dvs;
  logic [4:0]         div_cnt;
  logic [38:0]        prod;
  logic [7:0]         step;
  logic [14:0]        step_range;
  logic [7:0]         rem_q;
  logic [14:0]        rem_range;

  // Effective register values
  logic [4:0]         base_eff;
  logic [6:0]         range_eff;
  logic [4:0]         unit_eff;
  logic [31:0]        base32;
  logic [31:0]        hi32;
  logic [7:0]         base8;
  logic [7:0]         ob_diff;
  logic               line_out;

  // Shared divider step
  logic [8:0]         div_tmp;
  logic [8:0]         div_sub;
  logic               div_ge;
  logic [7:0]         div_rem_step;
  logic [31:0]        div_quo_step;
  logic               div_active;

  // Shared multiplier
  logic [31:0]        mul_opd;
  logic [38:0]        mul_out;

  // LEB128 group
  logic [6:0]         sleb_grp;
  logic signed [31:0] sleb_nxt;
  logic               sleb_term;

  // Opcode selection
  logic [32:0]        op_sum;
  logic               op_fits;
  logic               op_small;
  logic               addr_small;
  logic [7:0]         spec_byte;
  logic [7:0]         cap_byte;
  logic [7:0]         final_byte;

  logic               cfg_wr;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_LINE_BASE:   prdata = {27'd0, line_base};
      REG_LINE_RANGE:  prdata = {25'd0, line_range};
      REG_OPCODE_BASE: prdata = {24'd0, opcode_base};
      REG_MIN_INSTR:   prdata = {27'd0, min_instr_length};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    // A positive line base acts as zero; zero range and unit act as one.
    base_eff  = line_base[4] ? line_base : 5'd0;
    range_eff = (line_range == 7'd0) ? 7'd1 : line_range;
    unit_eff  = (min_instr_length == 5'd0) ? 5'd1 : min_instr_length;
    base32    = {{27{base_eff[4]}}, base_eff};
    base8     = {{3{base_eff[4]}}, base_eff};
    hi32      = base32 + {25'd0, range_eff} - 32'd1;
    ob_diff   = TOP_OPCODE - opcode_base;
    line_out  = ($signed(line_q) < $signed(base32)) || ($signed(line_q) > $signed(hi32));

    div_tmp      = {div_rem, div_quo[31]};
    div_sub      = div_tmp - {1'b0, div_dvs};
    div_ge       = (div_tmp >= {1'b0, div_dvs});
    div_rem_step = div_ge ? div_sub[7:0] : div_tmp[7:0];
    div_quo_step = {div_quo[30:0], div_ge};
    div_active   = (state == S_ADIV) || (state == S_SDIV) || (state == S_RDIV);

    case (state)
      S_SMUL:  mul_opd = {24'd0, step};
      S_RMUL:  mul_opd = {24'd0, rem_q};
      default: mul_opd = addr_q;
    endcase
    mul_out = 39'(range_eff) * 39'(mul_opd);

    sleb_grp  = sleb_val[6:0];
    sleb_nxt  = sleb_val >>> 7;
    sleb_term = ((sleb_nxt == 32'sd0) && !sleb_grp[6]) ||
                ((sleb_nxt == -32'sd1) && sleb_grp[6]);

    op_sum     = {1'b0, prod[31:0]} + {25'd0, adj};
    op_fits    = (prod[38:32] == 7'd0) && !op_sum[32];
    op_small   = (op_sum[31:0] <= {24'd0, ob_diff});
    addr_small = (addr_q < {23'd0, step, 1'b0});
    spec_byte  = op_sum[7:0] + opcode_base;
    cap_byte   = op_sum[7:0] - step_range[7:0] + opcode_base;
    final_byte = adj + rem_range[7:0] + opcode_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_strobe    <= 1'b0;
      line_base        <= 5'h1f;
      line_range       <= 7'd4;
      opcode_base      <= 8'd10;
      min_instr_length <= 5'd1;
    end else begin
      result_strobe <= 1'b0;

      if (cfg_wr) begin
        case (paddr[3:2])
          REG_LINE_BASE:   line_base        <= pwdata[4:0];
          REG_LINE_RANGE:  line_range       <= pwdata[6:0];
          REG_OPCODE_BASE: opcode_base      <= pwdata[7:0];
          REG_MIN_INSTR:   min_instr_length <= pwdata[4:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            line_q <= operands.line_delta;
            addr_q <= operands.addr_delta;
            state  <= S_LCHK;
          end
        end

        S_LCHK: begin
          if (line_out) begin
            result_strobe    <= 1'b1;
            result.out_byte  <= OP_ADVANCE_LINE;
            result.last_byte <= 1'b0;
            sleb_val         <= line_q;
            sleb_ret         <= S_ACHK;
            line_zero        <= 1'b1;
            adj              <= 8'd0 - base8;
            state            <= S_SLEB;
          end else begin
            line_zero <= (line_q == 32'sd0);
            adj       <= line_q[7:0] - base8;
            state     <= S_ACHK;
          end
        end

        S_ACHK: begin
          if (addr_q[31]) begin
            result_strobe    <= 1'b1;
            result.out_byte  <= OP_ADVANCE_PC;
            result.last_byte <= 1'b0;
            sleb_val         <= $signed(addr_q);
            sleb_ret         <= S_ZCHK;
            addr_q           <= 32'd0;
            state            <= S_SLEB;
          end else if (unit_eff == 5'd1) begin
            state <= S_ZCHK;
          end else begin
            div_quo <= addr_q;
            div_rem <= 8'd0;
            div_dvs <= {3'd0, unit_eff};
            div_cnt <= 5'd31;
            state   <= S_ADIV;
          end
        end

        S_ADIV: begin
          div_quo <= div_quo_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            addr_q <= div_quo_step;
            state  <= S_ZCHK;
          end
        end

        S_ZCHK: begin
          if ((addr_q == 32'd0) && line_zero) begin
            result_strobe    <= 1'b1;
            result.out_byte  <= OP_COPY;
            result.last_byte <= 1'b1;
            state            <= S_IDLE;
          end else begin
            prod    <= mul_out;
            // Step of the top special opcode: an 8-bit dividend, 8 iterations.
            div_quo <= {ob_diff, 24'd0};
            div_rem <= 8'd0;
            div_dvs <= {1'b0, range_eff};
            div_cnt <= 5'd7;
            state   <= S_SDIV;
          end
        end

        S_SDIV: begin
          div_quo <= div_quo_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            step  <= div_quo_step[7:0];
            state <= S_SMUL;
          end
        end

        S_SMUL: begin
          step_range <= mul_out[14:0];
          state      <= S_DECIDE;
        end

        S_DECIDE: begin
          result_strobe <= 1'b1;
          if (op_fits && op_small) begin
            result.out_byte  <= spec_byte;
            result.last_byte <= 1'b1;
            state            <= S_IDLE;
          end else if (op_fits && addr_small) begin
            result.out_byte  <= OP_CONST_ADD_PC;
            result.last_byte <= 1'b0;
            state            <= S_CAP;
          end else begin
            result.out_byte  <= OP_ADVANCE_PC;
            result.last_byte <= 1'b0;
            if (line_zero) begin
              sleb_val <= $signed(addr_q);
              sleb_ret <= S_FINAL;
              state    <= S_SLEB;
            end else if (step > 8'd1) begin
              div_quo <= addr_q;
              div_rem <= 8'd0;
              div_dvs <= step - 8'd1;
              div_cnt <= 5'd31;
              state   <= S_RDIV;
            end else begin
              rem_q <= 8'd0;
              state <= S_RMUL;
            end
          end
        end

        S_CAP: begin
          result_strobe    <= 1'b1;
          result.out_byte  <= cap_byte;
          result.last_byte <= 1'b1;
          state            <= S_IDLE;
        end

        S_RDIV: begin
          div_quo <= div_quo_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            rem_q  <= div_rem_step;
            addr_q <= addr_q - {24'd0, div_rem_step};
            state  <= S_RMUL;
          end
        end

        S_RMUL: begin
          rem_range <= mul_out[14:0];
          sleb_val  <= $signed(addr_q);
          sleb_ret  <= S_FINAL;
          state     <= S_SLEB;
        end

        S_SLEB: begin
          // One seven-bit group per cycle, least significant first.
          result_strobe    <= 1'b1;
          result.out_byte  <= {!sleb_term, sleb_grp};
          result.last_byte <= 1'b0;
          sleb_val         <= sleb_nxt;
          if (sleb_term) begin
            state <= sleb_ret;
          end
        end

        S_FINAL: begin
          result_strobe    <= 1'b1;
          result.out_byte  <= line_zero ? OP_COPY : final_byte;
          result.last_byte <= 1'b1;
          state            <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_last_idle, clk, rst, result_strobe && result.last_byte, !busy)
  `ASSERT_IMPL(a_strobe_past_busy, clk, rst, result_strobe, $past(busy))
  `ASSERT_IMPL(a_div_nonzero, clk, rst, div_active, div_dvs != 8'd0)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-table opcode encoder testbench
// Sends line/address delta words through the command port and checks every
// emitted line-program byte against an in-bench encoder. The register set is
// changed between phases over the APB port and read back. Phases cover the
// extremes and a few settings outside the documented ranges.
// ----------------------------------------------------------------------------
module tb;
  import ltoe_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     SETTLE_CYCLES = 120;
  localparam int     PHASE_ITEMS   = 14;
  localparam longint U32_MAX       = 64'd4294967295;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  ltoe_in_t    operands = '0;
  logic        result_strobe;
  ltoe_out_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the register file, starting from the reset values.
  logic [4:0]  cfg_line_base = 5'h1f;
  logic [6:0]  cfg_line_range = 7'd4;
  logic [7:0]  cfg_opcode_base = 8'd10;
  logic [4:0]  cfg_min_instr = 5'd1;

  ltoe_in_t    delta_q[$];
  ltoe_out_t   bytes_due[$];
  logic [7:0]  prog_bytes[$];
  ltoe_out_t   want_byte;

  int          gap_left = 0;
  bit          quiet = 1'b0;
  int          words_in = 0;
  int          bytes_out = 0;
  int          mismatches = 0;
  int          settings = 1;
  int          cycle_count = 0;

  line_table_opcode_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operands      (operands),
    .result_strobe (result_strobe),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void put_op(longint v);
    prog_bytes.push_back(v[7:0]);
  endfunction

  // Signed LEB128, least significant group first.
  function automatic void put_sleb(longint v);
    longint grp;
    bit     neg;
    bit     done;
    done = 1'b0;
    while (!done) begin
      grp = v & 64'h7f;
      neg = grp[6];
      v = (v - grp) / 128;
      if ((v == 0 && !neg) || (v == -1 && neg)) begin
        prog_bytes.push_back(grp[7:0]);
        done = 1'b1;
      end else begin
        prog_bytes.push_back(grp[7:0] | 8'h80);
      end
    end
  endfunction

  // Builds the byte program for one delta word and queues it as expected.
  function automatic void encode_line_step(ltoe_in_t it);
    longint lbase, lrange, obase, iunit, top;
    longint line, addr, adj, step, prod, op, rem;
    bit     done;
    lbase  = $signed(cfg_line_base);
    lrange = cfg_line_range;
    obase  = cfg_opcode_base;
    iunit  = cfg_min_instr;
    top    = TOP_OPCODE;
    line   = $signed(it.line_delta);
    addr   = $signed(it.addr_delta);
    if (lbase > 0) lbase = 0;
    if (lrange == 0) lrange = 1;
    if (iunit == 0) iunit = 1;
    prog_bytes.delete();
    done = 1'b0;

    if (line < lbase || line > lbase + lrange - 1) begin
      prog_bytes.push_back(OP_ADVANCE_LINE);
      put_sleb(line);
      line = 0;
    end
    if (addr < 0) begin
      prog_bytes.push_back(OP_ADVANCE_PC);
      put_sleb(addr);
      addr = 0;
    end else begin
      addr = addr / iunit;
    end

    if (addr == 0 && line == 0) begin
      prog_bytes.push_back(OP_COPY);
    end else begin
      adj  = line - lbase;
      step = (top - obase) / lrange;
      prod = lrange * addr;
      // A sum that overflows 32 unsigned bits falls through to advance-pc.
      if (prod <= U32_MAX && prod + adj <= U32_MAX) begin
        op = prod + adj;
        if (op <= top - obase) begin
          put_op(op + obase);
          done = 1'b1;
        end else if (addr < 2 * step) begin
          prog_bytes.push_back(OP_CONST_ADD_PC);
          put_op(op - step * lrange + obase);
          done = 1'b1;
        end
      end
      if (!done) begin
        prog_bytes.push_back(OP_ADVANCE_PC);
        if (adj == -lbase) begin
          put_sleb(addr);
          prog_bytes.push_back(OP_COPY);
        end else begin
          rem = (step - 1 > 0) ? addr % (step - 1) : 0;
          addr = addr - rem;
          put_sleb(addr);
          put_op(adj + lrange * rem + obase);
        end
      end
    end

    foreach (prog_bytes[k])
      bytes_due.push_back('{out_byte: prog_bytes[k], last_byte: (k == prog_bytes.size() - 1)});
  endfunction

  function automatic void add_delta(logic [31:0] line, logic [31:0] addr);
    delta_q.push_back('{line_delta: line, addr_delta: addr});
  endfunction

  // Mostly deltas near the special-opcode window, with some wide and raw ones.
  function automatic ltoe_in_t random_delta();
    longint   lbase, lrange, iunit, step, line, addr;
    ltoe_in_t it;
    lbase  = $signed(cfg_line_base);
    lrange = cfg_line_range;
    iunit  = cfg_min_instr;
    if (lbase > 0) lbase = 0;
    if (lrange == 0) lrange = 1;
    if (iunit == 0) iunit = 1;
    step = (longint'(TOP_OPCODE) - longint'(cfg_opcode_base)) / lrange;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        line = lbase - 2 + $urandom_range(0, lrange + 3);
        addr = $urandom_range(0, (2 * step + 4) * iunit + iunit - 1);
      end
      5, 6: begin
        line = ($urandom_range(0, 2) == 0) ? 0 : lbase + $urandom_range(0, lrange - 1);
        addr = $urandom_range(0, 1 << 20);
      end
      7: begin
        line = longint'($urandom_range(0, 600)) - 300;
        addr = -longint'($urandom_range(1, 1 << 16));
      end
      8: begin
        line = $signed($urandom);
        addr = $signed($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: line = 32'sh7fffffff;
          1: line = -64'sd2147483648;
          2: line = 0;
          default: line = -1;
        endcase
        case ($urandom_range(0, 3))
          0: addr = 32'sh7fffffff;
          1: addr = -64'sd2147483648;
          2: addr = 0;
          default: addr = -1;
        endcase
      end
    endcase
    it.line_delta = line[31:0];
    it.addr_delta = addr[31:0];
    return it;
  endfunction

  // Write one register, then read it back and check the implemented bits.
  task automatic reg_access(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] back;
    logic [31:0] mask;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LINE_BASE:   begin cfg_line_base   = val[4:0]; mask = 32'h1f; end
      REG_LINE_RANGE:  begin cfg_line_range  = val[6:0]; mask = 32'h7f; end
      REG_OPCODE_BASE: begin cfg_opcode_base = val[7:0]; mask = 32'hff; end
      default:         begin cfg_min_instr   = val[4:0]; mask = 32'h1f; end
    endcase
    if (((back ^ val) & mask) != 0)
      flag_mismatch($sformatf("register %0d read back %h, wrote %h", idx, back, val));
  endtask

  task automatic set_regs(input logic [31:0] lb, input logic [31:0] lr,
                          input logic [31:0] ob, input logic [31:0] mil);
    reg_access(REG_LINE_BASE, lb);
    reg_access(REG_LINE_RANGE, lr);
    reg_access(REG_OPCODE_BASE, ob);
    reg_access(REG_MIN_INSTR, mil);
    settings++;
  endtask

  task automatic wait_drained();
    while (delta_q.size() != 0 || start || bytes_due.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: presents the next word, holding start until busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        encode_line_step(operands);
        words_in++;
        if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (delta_q.size() != 0) begin
          operands <= delta_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed byte must match the oldest expected one.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      bytes_out++;
      if (bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h last %b", result.out_byte,
                                result.last_byte));
      end else begin
        want_byte = bytes_due.pop_front();
        if (result.out_byte != want_byte.out_byte || result.last_byte != want_byte.last_byte)
          flag_mismatch($sformatf("byte %h last %b, expected byte %h last %b",
                                  result.out_byte, result.last_byte,
                                  want_byte.out_byte, want_byte.last_byte));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int lr_pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: window -1..2, address step 61.
    add_delta(0, 0);
    add_delta(1, 0);
    add_delta(-1, 0);
    add_delta(2, 0);
    add_delta(3, 0);
    add_delta(0, 1);
    add_delta(1, 61);
    add_delta(0, 100);
    add_delta(0, 121);
    add_delta(0, 122);
    add_delta(0, 200);
    add_delta(1, 200);
    add_delta(2, 1000);
    add_delta(0, -1);
    add_delta(-64, -64);
    add_delta(63, 64);
    add_delta(-65, 0);
    add_delta(5, 0);
    add_delta(32'h7fffffff, 32'h7fffffff);
    add_delta(32'h80000000, 32'h80000000);
    add_delta(1, 32'h7fffffff);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(-16, 64, 1, 1);
        1: set_regs(0, 1, 200, 16);
        2: set_regs(-5, 14, 13, 4);
        // Values outside the documented ranges: positive base, zero range
        // and zero unit, then an opcode base that pushes bytes past 255.
        3: set_regs(15, 0, 0, 0);
        4: set_regs(-16, 127, 255, 31);
        5: begin
          lr_pick = $urandom_range(1, 64);
          set_regs(-$urandom_range(0, 16), lr_pick,
                   $urandom_range(1, (255 - 2 * lr_pick < 200) ? 255 - 2 * lr_pick : 200),
                   $urandom_range(1, 16));
        end
        default: begin
          quiet = 1'b1;
          set_regs(-3, 12, 13, 2);
        end
      endcase
      repeat (PHASE_ITEMS) delta_q.push_back(random_delta());
      wait_drained();
    end

    $display("Encoded %0d delta words into %0d line-program bytes over %0d register settings.",
             words_in, bytes_out, settings);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/ltoe_pkg.sv
src/line_table_opcode_encoder.sv
tb/tb.sv
